// ===== rtl/core/mts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the melody tone sequencer.
// Holds the command and mode codes, the payload word structs and the pitch table.
// No dependencies.
package mts_pkg;

	// Command codes carried in the input word
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_PLAY    = 3'd1;
	localparam logic [2:0] CMD_PAUSE   = 3'd2;
	localparam logic [2:0] CMD_RESUME  = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;
	localparam logic [2:0] CMD_STOP    = 3'd5;
	localparam logic [2:0] CMD_WRITE   = 3'd6;

	// Playback modes
	localparam logic [1:0] MODE_STOPPED = 2'd0;
	localparam logic [1:0] MODE_PLAYING = 2'd1;
	localparam logic [1:0] MODE_PAUSED  = 2'd2;

	// Configuration register indexes
	localparam int         CFG_IDX_W    = 1;
	localparam int         CFG_DATA_W   = 10;
	localparam logic [0:0] REG_TEMPO    = 1'd0;
	localparam logic [0:0] REG_SONG_LEN = 1'd1;

	localparam logic [9:0]  TEMPO_RESET  = 10'd120;
	localparam logic [23:0] ELAPSED_MAX  = 24'hFFFFFF;

	// Duration = length * 3750 / tempo, done as shift-add then restoring divide
	localparam logic [11:0] MS_PER_SIXTEENTH_K = 12'd3750;
	localparam int          MUL_STEPS = 12;
	localparam int          DIV_STEPS = 24;
	localparam int          CNT_W     = 5;

	// Duty resolution by frequency band
	localparam logic [13:0] HZ_BAND_LO = 14'd100;
	localparam logic [13:0] HZ_BAND_HI = 14'd200;
	localparam logic [3:0]  DUTY_BITS_12 = 4'd12;
	localparam logic [3:0]  DUTY_BITS_10 = 4'd10;
	localparam logic [3:0]  DUTY_BITS_8  = 4'd8;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  note_index;
		logic [6:0]  note_pitch;
		logic [11:0] note_length;
	} item_t;

	typedef struct packed {
		logic        tone_on;
		logic [13:0] tone_freq_hz;
		logic [3:0]  duty_bits;
		logic [11:0] half_duty;
		logic [1:0]  play_mode;
		logic [8:0]  note_position;
		logic        song_done;
	} result_t;

	// Truncated equal-tempered frequencies for MIDI notes 1..127; entry 0 holds 0
	localparam logic [13:0] PITCH_HZ [128] = '{
		14'd0,     14'd8,     14'd9,     14'd9,     14'd10,    14'd10,
		14'd11,    14'd12,    14'd12,    14'd13,    14'd14,    14'd15,
		14'd16,    14'd17,    14'd18,    14'd19,    14'd20,    14'd21,
		14'd23,    14'd24,    14'd25,    14'd27,    14'd29,    14'd30,
		14'd32,    14'd34,    14'd36,    14'd38,    14'd41,    14'd43,
		14'd46,    14'd48,    14'd51,    14'd55,    14'd58,    14'd61,
		14'd65,    14'd69,    14'd73,    14'd77,    14'd82,    14'd87,
		14'd92,    14'd97,    14'd103,   14'd110,   14'd116,   14'd123,
		14'd130,   14'd138,   14'd146,   14'd155,   14'd164,   14'd174,
		14'd184,   14'd195,   14'd207,   14'd220,   14'd233,   14'd246,
		14'd261,   14'd277,   14'd293,   14'd311,   14'd329,   14'd349,
		14'd369,   14'd391,   14'd415,   14'd440,   14'd466,   14'd493,
		14'd523,   14'd554,   14'd587,   14'd622,   14'd659,   14'd698,
		14'd739,   14'd783,   14'd830,   14'd880,   14'd932,   14'd987,
		14'd1046,  14'd1108,  14'd1174,  14'd1244,  14'd1318,  14'd1396,
		14'd1479,  14'd1567,  14'd1661,  14'd1760,  14'd1864,  14'd1975,
		14'd2093,  14'd2217,  14'd2349,  14'd2489,  14'd2637,  14'd2793,
		14'd2959,  14'd3135,  14'd3322,  14'd3520,  14'd3729,  14'd3951,
		14'd4186,  14'd4434,  14'd4698,  14'd4978,  14'd5274,  14'd5587,
		14'd5919,  14'd6271,  14'd6644,  14'd7040,  14'd7458,  14'd7902,
		14'd8372,  14'd8869,  14'd9397,  14'd9956,  14'd10548, 14'd11175,
		14'd11839, 14'd12543
	};

endpackage

// ===== rtl/core/melody_tone_sequencer.sv =====
`timescale 1ns / 1ps
// Melody tone sequencer: note store, playback control and tone programming.
// Depends on mts_pkg for payload structs, codes and the pitch table.
//
// channel   direction  handshake            word
// -------   ---------  -------------------  -------------------------------
// command   in         start / busy         item   (mts_pkg::item_t)
// result    out        result_valid strobe  result (mts_pkg::result_t)
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every command except a tick that begins a note gives its result in the cycle after
// acceptance. A tick that begins a note holds busy through one load step,
// 12 shift-add steps for length*3750 and 24 restoring-divide steps by the tempo;
// the result follows in the next cycle. Reset clears all control state; the note
// store is not cleared. The result strobe lasts one cycle and cannot be stalled.
module melody_tone_sequencer #(
	parameter int NOTE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  mts_pkg::item_t                   item,
	output logic                             result_valid,
	output mts_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_DIV
	} state_t;

	state_t state_q;
	logic [mts_pkg::CNT_W-1:0] cnt_q;
	logic [1:0]  mode_q;
	logic        loaded_q;
	logic [8:0]  pos_q;
	logic        active_q;
	logic [23:0] dur_q;
	logic [23:0] elapsed_q;
	logic        tone_on_q;
	logic [13:0] freq_q;
	logic [3:0]  bits_q;
	logic [9:0]  tempo_q;
	logic [8:0]  song_len_q;
	logic        done_q;
	logic        result_valid_q;

	// Note store: pitch in [18:12], length in [11:0]
	logic [18:0] note_mem [NOTE_DEPTH];
	logic [18:0] mem_rd_q;
	logic        mem_we;

	// Shift-add multiplier and restoring divider
	logic [23:0] acc_q;
	logic [23:0] mcand_q;
	logic [11:0] mplier_q;
	logic [23:0] dvd_q;
	logic [9:0]  rem_q;
	logic [23:0] acc_nxt;
	logic [9:0]  divisor;
	logic [10:0] trial;
	logic        q_bit;
	logic [9:0]  rem_nxt;
	logic [23:0] quo_nxt;

	logic        accept;
	logic [8:0]  eff_len;
	logic [23:0] elapsed_inc;
	logic [9:0]  pos_inc;
	logic [6:0]  ld_pitch;
	logic [13:0] ld_hz;
	logic [11:0] half_duty;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign mem_we    = accept && (item.cmd == mts_pkg::CMD_WRITE) &&
	                   ({24'd0, item.note_index} < 32'(NOTE_DEPTH));

	assign eff_len = (32'(song_len_q) > 32'(NOTE_DEPTH)) ? 9'(NOTE_DEPTH) : song_len_q;
	assign elapsed_inc = (active_q && (elapsed_q != mts_pkg::ELAPSED_MAX)) ?
	                     elapsed_q + 24'd1 : elapsed_q;
	assign pos_inc = {1'b0, pos_q} + 10'd1;

	assign ld_pitch = mem_rd_q[18:12];
	assign ld_hz    = mts_pkg::PITCH_HZ[ld_pitch];

	assign acc_nxt = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign divisor = (tempo_q == 10'd0) ? 10'd1 : tempo_q;
	assign trial   = {rem_q, dvd_q[23]};
	assign q_bit   = (trial >= {1'b0, divisor});
	assign rem_nxt = q_bit ? 10'(trial - {1'b0, divisor}) : trial[9:0];
	assign quo_nxt = {dvd_q[22:0], q_bit};

	always_comb begin
		case (bits_q)
			mts_pkg::DUTY_BITS_12: half_duty = 12'd2048;
			mts_pkg::DUTY_BITS_10: half_duty = 12'd512;
			default:               half_duty = 12'd128;
		endcase
	end

	assign result_valid         = result_valid_q;
	assign result.tone_on       = tone_on_q;
	assign result.tone_freq_hz  = freq_q;
	assign result.duty_bits     = bits_q;
	assign result.half_duty     = tone_on_q ? half_duty : 12'd0;
	assign result.play_mode     = mode_q;
	assign result.note_position = pos_q;
	assign result.song_done     = done_q;

	// The store is read at the current position every cycle, so the entry is
	// ready in the cycle after a tick that begins a note.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			note_mem[AW'(item.note_index)] <= {item.note_pitch, item.note_length};
		end
		mem_rd_q <= note_mem[AW'(pos_q)];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				acc_q    <= 24'd0;
				mcand_q  <= {12'd0, mem_rd_q[11:0]};
				mplier_q <= mts_pkg::MS_PER_SIXTEENTH_K;
			end
			S_MUL: begin
				acc_q    <= acc_nxt;
				mcand_q  <= {mcand_q[22:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[11:1]};
				if (cnt_q == mts_pkg::CNT_W'(mts_pkg::MUL_STEPS - 1)) begin
					dvd_q <= acc_nxt;
					rem_q <= 10'd0;
				end
			end
			S_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= quo_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			mode_q         <= mts_pkg::MODE_STOPPED;
			loaded_q       <= 1'b0;
			pos_q          <= 9'd0;
			active_q       <= 1'b0;
			dur_q          <= 24'd0;
			elapsed_q      <= 24'd0;
			tone_on_q      <= 1'b0;
			freq_q         <= 14'd0;
			bits_q         <= mts_pkg::DUTY_BITS_8;
			tempo_q        <= mts_pkg::TEMPO_RESET;
			song_len_q     <= 9'd0;
			done_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mts_pkg::REG_TEMPO:    tempo_q    <= cfg_data;
					mts_pkg::REG_SONG_LEN: song_len_q <= cfg_data[8:0];
					default: ;
				endcase
			end

			result_valid_q <= 1'b0;
			done_q         <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_valid_q <= 1'b1;
						unique case (item.cmd)
							mts_pkg::CMD_TICK: begin
								elapsed_q <= elapsed_inc;
								if (mode_q == mts_pkg::MODE_PLAYING && loaded_q) begin
									if (pos_q >= eff_len) begin
										// Empty or overrun song
										mode_q    <= mts_pkg::MODE_STOPPED;
										tone_on_q <= 1'b0;
										done_q    <= 1'b1;
									end else if (!active_q) begin
										active_q       <= 1'b1;
										elapsed_q      <= 24'd0;
										result_valid_q <= 1'b0;
										state_q        <= S_LOAD;
									end else if (elapsed_inc >= dur_q) begin
										tone_on_q <= 1'b0;
										active_q  <= 1'b0;
										if (pos_inc >= {1'b0, eff_len}) begin
											mode_q <= mts_pkg::MODE_STOPPED;
											pos_q  <= 9'd0;
											done_q <= 1'b1;
										end else begin
											pos_q <= pos_inc[8:0];
										end
									end
								end
							end
							mts_pkg::CMD_PLAY: begin
								loaded_q <= 1'b1;
								pos_q    <= 9'd0;
								active_q <= 1'b0;
								mode_q   <= mts_pkg::MODE_PLAYING;
							end
							mts_pkg::CMD_PAUSE: begin
								if (mode_q == mts_pkg::MODE_PLAYING) begin
									mode_q    <= mts_pkg::MODE_PAUSED;
									tone_on_q <= 1'b0;
								end
							end
							mts_pkg::CMD_RESUME: begin
								if (mode_q == mts_pkg::MODE_PAUSED) begin
									mode_q <= mts_pkg::MODE_PLAYING;
								end
							end
							mts_pkg::CMD_RESTART: begin
								pos_q    <= 9'd0;
								active_q <= 1'b0;
								mode_q   <= mts_pkg::MODE_PLAYING;
							end
							mts_pkg::CMD_STOP: begin
								tone_on_q <= 1'b0;
								pos_q     <= 9'd0;
								active_q  <= 1'b0;
								mode_q    <= mts_pkg::MODE_STOPPED;
								loaded_q  <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_LOAD: begin
					// A rest silences the tone but keeps the last frequency.
					if (ld_pitch != 7'd0) begin
						freq_q    <= ld_hz;
						tone_on_q <= 1'b1;
						if (ld_hz < mts_pkg::HZ_BAND_LO) begin
							bits_q <= mts_pkg::DUTY_BITS_12;
						end else if (ld_hz < mts_pkg::HZ_BAND_HI) begin
							bits_q <= mts_pkg::DUTY_BITS_10;
						end else begin
							bits_q <= mts_pkg::DUTY_BITS_8;
						end
					end else begin
						tone_on_q <= 1'b0;
					end
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == mts_pkg::CNT_W'(mts_pkg::MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == mts_pkg::CNT_W'(mts_pkg::DIV_STEPS - 1)) begin
						cnt_q          <= '0;
						dur_q          <= quo_nxt;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_strobe_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	a_short_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd != mts_pkg::CMD_TICK) |=> result_valid)
		else $error("non-tick command gave no result in the next cycle");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.song_done) |->
		(result.play_mode == mts_pkg::MODE_STOPPED && !result.tone_on))
		else $error("song end reported while not stopped and silent");

	a_busy_playing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (active_q && mode_q == mts_pkg::MODE_PLAYING))
		else $error("note start in progress outside of playback");

endmodule
